>>> design/obsr_pkg.sv
// Shared types and constants for the order book slippage regression unit.
package obsr_pkg;

	localparam int MAX_LEVELS = 64;
	localparam int LVL_W      = 7;
	localparam int PRICE_W    = 24;
	localparam int QTY_W      = 32;
	localparam int TGT_W      = 28;
	localparam int AX_W       = 34;
	localparam int AY_W       = 30;
	localparam int AXY_W      = 58;
	localparam int AXX_W      = 62;
	localparam int WIDE_W     = 128;
	localparam int MPL_W      = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH) + 1;

	localparam logic [TGT_W-1:0] TARGET_RESET = TGT_W'(25000000);

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SINGULAR = 2'd1;
	localparam logic [1:0] ST_LIMIT    = 2'd2;

	// Totals of one snapshot, handed from front to back
	typedef struct packed {
		logic [AX_W-1:0]    acc_x;
		logic [AY_W-1:0]    acc_y;
		logic [AXY_W-1:0]   acc_xy;
		logic [AXX_W-1:0]   acc_xx;
		logic [LVL_W-1:0]   n;
		logic [PRICE_W-1:0] best;
		logic               limit;
	} snap_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_NXX,
		BK_XX,
		BK_CHK,
		BK_NXY,
		BK_XY,
		BK_NT,
		BK_MAG,
		BK_T2,
		BK_NUM,
		BK_DEN,
		BK_ABS,
		BK_DIV,
		BK_RND,
		BK_NEG,
		BK_SAT
	} bk_state_t;

endpackage

>>> design/order_book_slippage_regression_unit.sv
// Order book slippage regression unit: top level.
//
// Input channel: one ask level per beat (level_price, level_quantity,
// last_level), best level first, qualified by in_valid and in_stall.
// A beat with last_level set closes the snapshot and produces one result
// beat on the output channel (predicted_price, slippage, fit_status,
// levels_used), qualified by out_valid and out_stall.
// The front end takes one level per cycle while in_stall is low, through a
// three-stage pipeline, and pushes each closed snapshot into a four-entry
// queue; in_stall rises once queued and in-flight snapshots fill it.
// The back end fits each snapshot with a bit-serial shift-add multiplier
// and a 128-step restoring divider; a limit snapshot skips the fit and
// goes straight to the result register, and a singular one stops after
// the determinant check.
// While out_stall is high the result beat holds; the back end finishes its
// next fit and waits, and the front end keeps filling the queue.
// cfg_we writes target_notional; write it only while the unit is idle.
// Reset clears all running sums, the queue and the result valid flag, and
// sets target_notional to 25000000.
module order_book_slippage_regression_unit import obsr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [TGT_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PRICE_W-1:0] level_price,
	input  logic [QTY_W-1:0]   level_quantity,
	input  logic               last_level,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] predicted_price,
	output logic signed [31:0] slippage,
	output logic [1:0]         fit_status,
	output logic [LVL_W-1:0]   levels_used
);

	logic [TGT_W-1:0]  target_q;
	logic              push;
	snap_t             push_data;
	logic              pop;
	snap_t             pop_data;
	logic              not_empty;
	logic [QCNT_W-1:0] q_count;

	// Target register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     target_q <= TARGET_RESET;
		else if (cfg_we) target_q <= cfg_wdata;
	end

	obsr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.level_price    (level_price),
		.level_quantity (level_quantity),
		.last_level     (last_level),
		.target         (target_q),
		.q_count        (q_count),
		.push           (push),
		.push_data      (push_data)
	);

	obsr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty),
		.count     (q_count)
	);

	obsr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.target          (target_q),
		.q_valid         (not_empty),
		.q_data          (pop_data),
		.q_pop           (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.predicted_price (predicted_price),
		.slippage        (slippage),
		.fit_status      (fit_status),
		.levels_used     (levels_used)
	);

endmodule

>>> design/obsr_queue.sv
// Small snapshot queue between the level front end and the fit back end.
module obsr_queue import obsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  snap_t             push_data,
	input  logic              pop,
	output snap_t             pop_data,
	output logic              not_empty,
	output logic [QCNT_W-1:0] count
);

	snap_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign pop_data  = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Store pushed snapshot
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

>>> design/obsr_front.sv
// Level front end: notional accumulation and running regression sums.
module obsr_front import obsr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PRICE_W-1:0] level_price,
	input  logic [QTY_W-1:0]   level_quantity,
	input  logic               last_level,
	input  logic [TGT_W-1:0]   target,
	input  logic [QCNT_W-1:0]  q_count,
	output logic               push,
	output snap_t              push_data
);

	localparam int PROD_W = PRICE_W + QTY_W;
	localparam int ADD_W  = PROD_W - 18;
	localparam logic [TGT_W-1:0] CUM_MAX = '1;

	logic                     accept;
	// stage 1
	logic                     vld_s1;
	logic [PROD_W-1:0]        prod_s1;
	logic [PRICE_W-1:0]       price_s1;
	logic                     last_s1;
	// stage 2
	logic                     vld_s2;
	logic [TGT_W-1:0]         x_s2;
	logic [PRICE_W-1:0]       price_s2;
	logic                     incl_s2;
	logic                     last_s2;
	logic [LVL_W-1:0]         n_s2;
	logic [PRICE_W-1:0]       best_s2;
	logic                     lim_s2;
	// stage 3
	logic                     vld_s3;
	logic [TGT_W+PRICE_W-1:0] xp_s3;
	logic [2*TGT_W-1:0]       xx_s3;
	logic [TGT_W-1:0]         x_s3;
	logic [PRICE_W-1:0]       price_s3;
	logic                     incl_s3;
	logic                     last_s3;
	logic [LVL_W-1:0]         n_s3;
	logic [PRICE_W-1:0]       best_s3;
	logic                     lim_s3;
	// book state
	logic [TGT_W-1:0]         cum_q;
	logic [LVL_W-1:0]         cnt_q;
	logic [PRICE_W-1:0]       best_q;
	logic                     crossed_q;
	logic                     limit_q;
	logic [AX_W-1:0]          acc_x_q;
	logic [AY_W-1:0]          acc_y_q;
	logic [AXY_W-1:0]         acc_xy_q;
	logic [AXX_W-1:0]         acc_xx_q;
	// stage 2 logic
	logic [ADD_W-1:0]         add;
	logic [TGT_W-1:0]         room;
	logic [TGT_W-1:0]         cum_new;
	logic                     open;
	logic                     take;
	logic [LVL_W-1:0]         cnt_nx;
	logic [PRICE_W-1:0]       best_nx;
	logic                     lim_nx;
	logic                     crs_nx;
	// accumulate logic
	logic [AX_W-1:0]          ax_nx;
	logic [AY_W-1:0]          ay_nx;
	logic [AXY_W-1:0]         axy_nx;
	logic [AXX_W-1:0]         axx_nx;
	logic [QCNT_W-1:0]        pending;

	// Hold input while the queue might not take every snapshot in flight
	assign pending  = q_count + QCNT_W'(last_s1 & vld_s1) + QCNT_W'(last_s2 & vld_s2)
		+ QCNT_W'(last_s3 & vld_s3);
	assign in_stall = (pending >= QCNT_W'(QUEUE_DEPTH));
	assign accept   = in_valid && !in_stall;

	// Saturating notional and level admission
	always_comb begin
		add     = prod_s1[PROD_W-1:18];
		room    = CUM_MAX - cum_q;
		cum_new = (ADD_W'(room) <= add) ? CUM_MAX : cum_q + add[TGT_W-1:0];
		open    = vld_s1 && !crossed_q && !limit_q;
		take    = open && (cnt_q < LVL_W'(MAX_LEVELS));
		cnt_nx  = take ? cnt_q + 1'b1 : cnt_q;
		best_nx = (take && cnt_q == '0) ? price_s1 : best_q;
		lim_nx  = limit_q || (open && !take);
		crs_nx  = crossed_q || (take && cum_new >= target);
	end

	// Fold stage 3 contribution into the sums
	always_comb begin
		ax_nx  = acc_x_q;
		ay_nx  = acc_y_q;
		axy_nx = acc_xy_q;
		axx_nx = acc_xx_q;
		if (incl_s3) begin
			ax_nx  = acc_x_q + AX_W'(x_s3);
			ay_nx  = acc_y_q + AY_W'(price_s3);
			axy_nx = acc_xy_q + AXY_W'(xp_s3);
			axx_nx = acc_xx_q + AXX_W'(xx_s3);
		end
	end

	assign push             = vld_s3 && last_s3;
	assign push_data.acc_x  = ax_nx;
	assign push_data.acc_y  = ay_nx;
	assign push_data.acc_xy = axy_nx;
	assign push_data.acc_xx = axx_nx;
	assign push_data.n      = n_s3;
	assign push_data.best   = best_s3;
	assign push_data.limit  = lim_s3;

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		prod_s1  <= PROD_W'(level_price) * PROD_W'(level_quantity);
		price_s1 <= level_price;
		last_s1  <= last_level;
		x_s2     <= cum_new;
		price_s2 <= price_s1;
		incl_s2  <= take;
		last_s2  <= last_s1;
		n_s2     <= cnt_nx;
		best_s2  <= best_nx;
		lim_s2   <= lim_nx;
		xp_s3    <= (TGT_W+PRICE_W)'(x_s2) * (TGT_W+PRICE_W)'(price_s2);
		xx_s3    <= (2*TGT_W)'(x_s2) * (2*TGT_W)'(x_s2);
		x_s3     <= x_s2;
		price_s3 <= price_s2;
		incl_s3  <= incl_s2 & vld_s2;
		last_s3  <= last_s2;
		n_s3     <= n_s2;
		best_s3  <= best_s2;
		lim_s3   <= lim_s2;
	end

	// Update book state; drop it on the last level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cum_q     <= '0;
			cnt_q     <= '0;
			best_q    <= '0;
			crossed_q <= 1'b0;
			limit_q   <= 1'b0;
		end else if (vld_s1) begin
			if (last_s1) begin
				cum_q     <= '0;
				cnt_q     <= '0;
				best_q    <= '0;
				crossed_q <= 1'b0;
				limit_q   <= 1'b0;
			end else begin
				if (take) cum_q <= cum_new;
				cnt_q     <= cnt_nx;
				best_q    <= best_nx;
				crossed_q <= crs_nx;
				limit_q   <= lim_nx;
			end
		end
	end

	// Running sums; clear after the snapshot is pushed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q  <= '0;
			acc_y_q  <= '0;
			acc_xy_q <= '0;
			acc_xx_q <= '0;
		end else if (vld_s3) begin
			if (last_s3) begin
				acc_x_q  <= '0;
				acc_y_q  <= '0;
				acc_xy_q <= '0;
				acc_xx_q <= '0;
			end else begin
				acc_x_q  <= ax_nx;
				acc_y_q  <= ay_nx;
				acc_xy_q <= axy_nx;
				acc_xx_q <= axx_nx;
			end
		end
	end

endmodule

>>> design/obsr_mul.sv
// Bit-serial shift-add multiplier, product modulo 2^128.
module obsr_mul import obsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] mcand,
	input  logic [MPL_W-1:0]  mplier,
	output logic              done,
	output logic [WIDE_W-1:0] prod
);

	logic              busy_q;
	logic [WIDE_W-1:0] acc_q;
	logic [WIDE_W-1:0] mc_q;
	logic [MPL_W-1:0]  mp_q;

	// Finish as soon as no multiplier bits remain
	assign done = busy_q && (mp_q == '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)    busy_q <= 1'b0;
		else if (start) busy_q <= 1'b1;
		else if (done)  busy_q <= 1'b0;
	end

	// One multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= mcand;
			mp_q  <= mplier;
		end else if (busy_q && mp_q != '0) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[WIDE_W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[MPL_W-1:1]};
		end
	end

endmodule

>>> design/obsr_div.sv
// Restoring divider, one quotient bit per cycle over 128 bits.
module obsr_div import obsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] num,
	input  logic [WIDE_W-1:0] den,
	output logic              done,
	output logic [WIDE_W-1:0] quo,
	output logic [WIDE_W-1:0] rem
);

	localparam int CNT_W = $clog2(WIDE_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDE_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WIDE_W-1:0] rem_q;
	logic [WIDE_W-1:0] quo_q;
	logic [WIDE_W-1:0] den_q;
	logic [WIDE_W-1:0] r_sh;
	logic              ge;

	assign r_sh = {rem_q[WIDE_W-2:0], quo_q[WIDE_W-1]};
	assign ge   = (r_sh >= den_q);
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

	// Step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) busy_q <= 1'b0;
			end
		end
	end

	// Shift in dividend bits, subtract where the remainder allows
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? r_sh - den_q : r_sh;
			quo_q <= {quo_q[WIDE_W-2:0], ge};
		end
	end

endmodule

>>> design/obsr_back.sv
// Fit back end: line fit, prediction at target and result register.
module obsr_back import obsr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [TGT_W-1:0]   target,
	input  logic               q_valid,
	input  snap_t              q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] predicted_price,
	output logic signed [31:0] slippage,
	output logic [1:0]         fit_status,
	output logic [LVL_W-1:0]   levels_used
);

	localparam int NT_W = LVL_W + TGT_W;

	bk_state_t         state_q;
	bk_state_t         state_d;
	snap_t             snap_q;
	logic              started_q;
	logic [1:0]        st_q;
	logic [WIDE_W-1:0] p1_q;
	logic [WIDE_W-1:0] d_q;
	logic [WIDE_W-1:0] nn_q;
	logic [WIDE_W-1:0] t2_q;
	logic [WIDE_W-1:0] num_q;
	logic [WIDE_W-1:0] den_q;
	logic [WIDE_W-1:0] q_q;
	logic [NT_W-1:0]   nt_q;
	logic [NT_W-1:0]   mmag_q;
	logic              mneg_q;
	logic              qneg_q;
	logic              out_valid_q;
	logic [31:0]       pred_q;
	logic [31:0]       slip_q;
	logic [1:0]        stat_q;
	logic [LVL_W-1:0]  used_q;

	logic              mul_start;
	logic              mul_done;
	logic [WIDE_W-1:0] mcand;
	logic [MPL_W-1:0]  mplier;
	logic [WIDE_W-1:0] prod;
	logic              div_start;
	logic              div_done;
	logic [WIDE_W-1:0] quo;
	logic [WIDE_W-1:0] rem;
	logic              out_free;
	logic [WIDE_W-1:0] diff;

	function automatic logic [31:0] sat32(input logic [WIDE_W-1:0] v);
		logic [31:0] r;
		if (v[WIDE_W-1]) r = (&v[WIDE_W-1:31]) ? v[31:0] : 32'h8000_0000;
		else             r = (v[WIDE_W-1:31] == '0) ? v[31:0] : 32'h7FFF_FFFF;
		return r;
	endfunction

	obsr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mcand),
		.mplier (mplier),
		.done   (mul_done),
		.prod   (prod)
	);

	obsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo),
		.rem    (rem)
	);

	assign out_free        = !out_valid_q || !out_stall;
	assign diff            = q_q - WIDE_W'(snap_q.best);
	assign out_valid       = out_valid_q;
	assign predicted_price = pred_q;
	assign slippage        = slip_q;
	assign fit_status      = stat_q;
	assign levels_used     = used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			started_q <= mul_start || div_start || (started_q && !(mul_done || div_done));
		end
	end

	// Sequence the fit steps and choose multiplier operands
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		mcand     = '0;
		mplier    = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = q_data.limit ? BK_SAT : BK_NXX;
				end
			end
			BK_NXX: begin
				mcand     = WIDE_W'(snap_q.acc_xx);
				mplier    = MPL_W'(snap_q.n);
				mul_start = !started_q;
				if (started_q && mul_done) state_d = BK_XX;
			end
			BK_XX: begin
				mcand     = WIDE_W'(snap_q.acc_x);
				mplier    = MPL_W'(snap_q.acc_x);
				mul_start = !started_q;
				if (started_q && mul_done) state_d = BK_CHK;
			end
			BK_CHK: state_d = (d_q == '0) ? BK_SAT : BK_NXY;
			BK_NXY: begin
				mcand     = WIDE_W'(snap_q.acc_xy);
				mplier    = MPL_W'(snap_q.n);
				mul_start = !started_q;
				if (started_q && mul_done) state_d = BK_XY;
			end
			BK_XY: begin
				mcand     = WIDE_W'(snap_q.acc_x);
				mplier    = MPL_W'(snap_q.acc_y);
				mul_start = !started_q;
				if (started_q && mul_done) state_d = BK_NT;
			end
			BK_NT:  state_d = BK_MAG;
			BK_MAG: state_d = BK_T2;
			BK_T2: begin
				mcand     = nn_q;
				mplier    = MPL_W'(mmag_q);
				mul_start = !started_q;
				if (started_q && mul_done) state_d = BK_NUM;
			end
			BK_NUM: begin
				mcand     = d_q;
				mplier    = MPL_W'(snap_q.acc_y);
				mul_start = !started_q;
				if (started_q && mul_done) state_d = BK_DEN;
			end
			BK_DEN: begin
				mcand     = d_q;
				mplier    = MPL_W'(snap_q.n);
				mul_start = !started_q;
				if (started_q && mul_done) state_d = BK_ABS;
			end
			BK_ABS: state_d = BK_DIV;
			BK_DIV: begin
				div_start = !started_q;
				if (started_q && div_done) state_d = BK_RND;
			end
			BK_RND: state_d = BK_NEG;
			BK_NEG: state_d = BK_SAT;
			BK_SAT: if (out_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// Fit datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			snap_q <= q_data;
			st_q   <= q_data.limit ? ST_LIMIT : ST_OK;
		end
		if (state_q == BK_NXX && started_q && mul_done) p1_q <= prod;
		if (state_q == BK_XX && started_q && mul_done) d_q <= p1_q - prod;
		if (state_q == BK_CHK && d_q == '0) st_q <= ST_SINGULAR;
		if (state_q == BK_NXY && started_q && mul_done) p1_q <= prod;
		if (state_q == BK_XY && started_q && mul_done) nn_q <= p1_q - prod;
		if (state_q == BK_NT) nt_q <= NT_W'(snap_q.n) * NT_W'(target);
		if (state_q == BK_MAG) begin
			mneg_q <= nt_q < NT_W'(snap_q.acc_x);
			mmag_q <= (nt_q < NT_W'(snap_q.acc_x)) ? NT_W'(snap_q.acc_x) - nt_q
				: nt_q - NT_W'(snap_q.acc_x);
		end
		if (state_q == BK_T2 && started_q && mul_done) t2_q <= mneg_q ? '0 - prod : prod;
		if (state_q == BK_NUM && started_q && mul_done) num_q <= prod + t2_q;
		if (state_q == BK_DEN && started_q && mul_done) den_q <= prod;
		if (state_q == BK_ABS) begin
			qneg_q <= num_q[WIDE_W-1];
			num_q  <= num_q[WIDE_W-1] ? '0 - num_q : num_q;
		end
		// Round half away from zero on the magnitude
		if (state_q == BK_RND)
			q_q <= quo + WIDE_W'({rem[WIDE_W-2:0], 1'b0} >= den_q);
		if (state_q == BK_NEG && qneg_q) q_q <= '0 - q_q;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == BK_SAT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_SAT && out_free) begin
			pred_q <= (st_q == ST_OK) ? sat32(q_q) : '0;
			slip_q <= (st_q == ST_OK) ? sat32(diff) : '0;
			stat_q <= st_q;
			used_q <= snap_q.n;
		end
	end

endmodule
